// ===== design/psc_pkg.sv =====
// shared types and constants for the clamped pid speed controller
// no dependencies; used by every module of the block

package psc_pkg;

  // widths of the work fields
  localparam int unsigned CountW = 16;
  localparam int unsigned GainW  = 12;
  localparam int unsigned LimitW = 15;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned DiffW  = 18;
  localparam int unsigned SumW   = 32;
  localparam int unsigned PropW  = GainW + 1 + ErrW;
  localparam int unsigned IntgW  = GainW + 1 + SumW;
  localparam int unsigned DerW   = GainW + 1 + DiffW;
  localparam int unsigned AccW   = IntgW + 1;
  localparam int unsigned QuotW  = AccW - 8;

  // register reset values
  localparam logic [GainW-1:0]  GainPReset  = 12'd1408;
  localparam logic [GainW-1:0]  GainIReset  = 12'd166;
  localparam logic [GainW-1:0]  GainDReset  = 12'd256;
  localparam logic [LimitW-1:0] LimitReset  = 15'd1000;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_GAIN_P      = 2'd0,
    CFG_GAIN_I      = 2'd1,
    CFG_GAIN_D      = 2'd2,
    CFG_DRIVE_LIMIT = 2'd3
  } cfg_idx_e;

  // error terms handed from the error stage to the gain stage
  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [SumW-1:0]  err_sum;
    logic signed [DiffW-1:0] err_diff;
    logic                    tgt_zero;
  } err_terms_t;

  // products handed from the gain stage to the sum and clamp stage
  typedef struct packed {
    logic signed [PropW-1:0] prop;
    logic signed [IntgW-1:0] intg;
    logic signed [DerW-1:0]  deriv;
    logic                    tgt_zero;
  } products_t;

endpackage

// ===== design/psc_if.sv =====
// valid/ready channel interfaces for input and result words
// depends on psc_pkg for field widths

interface psc_in_if;
  import psc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CountW-1:0] measured_count;
  logic signed [CountW-1:0] target_speed;

  modport source (output valid, measured_count, target_speed, input ready);
  modport sink   (input valid, measured_count, target_speed, output ready);
endinterface

interface psc_out_if;
  import psc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CountW-1:0] drive_value;

  modport source (output valid, drive_value, input ready);
  modport sink   (input valid, drive_value, output ready);
endinterface

// ===== design/psc_error_stage.sv =====
// input stage: error, saturating integral and derivative difference
// depends on psc_pkg; holds the controller state registers

module psc_error_stage import psc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CountW-1:0] measured_count_i,
  input  logic signed [CountW-1:0] target_speed_i,
  output logic                     terms_valid_o,
  input  logic                     terms_ready_i,
  output err_terms_t               terms_o
);

  logic                    valid_q, valid_d;
  err_terms_t              terms_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [ErrW-1:0]  prev_q;
  logic                    accept;
  logic signed [ErrW-1:0]  err;
  logic signed [SumW:0]    sum_wide;
  logic signed [SumW-1:0]  sum_sat;
  logic signed [DiffW-1:0] diff;

  assign in_ready_o    = !valid_q || terms_ready_i;
  assign accept        = in_valid_i && in_ready_o;
  assign terms_valid_o = valid_q;
  assign terms_o       = terms_q;

  // error and saturating running sum
  always_comb begin
    err      = ErrW'(measured_count_i) - ErrW'(target_speed_i);
    sum_wide = (SumW+1)'(sum_q) + (SumW+1)'(err);
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
    diff = DiffW'(err) - DiffW'(prev_q);
  end

  // stage valid
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (terms_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sum_q   <= '0;
      prev_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        sum_q  <= sum_sat;
        prev_q <= err;
      end
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      terms_q.err      <= err;
      terms_q.err_sum  <= sum_sat;
      terms_q.err_diff <= diff;
      terms_q.tgt_zero <= (target_speed_i == '0);
    end
  end

  // an accepted word always leaves valid terms behind
  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_q) else $error("error stage lost an accepted word");

  // previous error tracks the error of the last accepted word
  a_prev_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> prev_q == terms_q.err && sum_q == terms_q.err_sum)
    else $error("state and stage payload disagree");

  // adding a non-negative error to a non-negative sum never goes negative
  a_sum_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !sum_q[SumW-1] && !err[ErrW-1] |=> !sum_q[SumW-1])
    else $error("integral wrapped instead of saturating");

endmodule

// ===== design/psc_gain_stage.sv =====
// gain stage: three parallel products of gains and error terms
// depends on psc_pkg

module psc_gain_stage import psc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [GainW-1:0]  gain_p_i,
  input  logic [GainW-1:0]  gain_i_i,
  input  logic [GainW-1:0]  gain_d_i,
  input  logic              terms_valid_i,
  output logic              terms_ready_o,
  input  err_terms_t        terms_i,
  output logic              prod_valid_o,
  input  logic              prod_ready_i,
  output products_t         prod_o
);

  logic      valid_q, valid_d;
  products_t prod_q;
  products_t prod_d;
  logic      accept;

  assign terms_ready_o = !valid_q || prod_ready_i;
  assign accept        = terms_valid_i && terms_ready_o;
  assign prod_valid_o  = valid_q;
  assign prod_o        = prod_q;

  // unsigned gains times signed terms
  always_comb begin
    prod_d.prop     = $signed({1'b0, gain_p_i}) * terms_i.err;
    prod_d.intg     = $signed({1'b0, gain_i_i}) * terms_i.err_sum;
    prod_d.deriv    = $signed({1'b0, gain_d_i}) * terms_i.err_diff;
    prod_d.tgt_zero = terms_i.tgt_zero;
  end

  // stage valid
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (prod_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
    end
  end

endmodule

// ===== design/psc_sum_clamp.sv =====
// output stage: sum of products, truncating divide by 256, clamp, zero force
// depends on psc_pkg; drives the result register

module psc_sum_clamp import psc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [LimitW-1:0]        drive_limit_i,
  input  logic                     prod_valid_i,
  output logic                     prod_ready_o,
  input  products_t                prod_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CountW-1:0] drive_value_o
);

  logic                     valid_q, valid_d;
  logic signed [CountW-1:0] drive_q;
  logic signed [CountW-1:0] drive_d;
  logic                     accept;
  logic signed [AccW-1:0]   acc;
  logic signed [QuotW-1:0]  quot;
  logic signed [QuotW-1:0]  lim_pos;
  logic signed [QuotW-1:0]  lim_neg;

  assign prod_ready_o  = !valid_q || out_ready_i;
  assign accept        = prod_valid_i && prod_ready_o;
  assign out_valid_o   = valid_q;
  assign drive_value_o = drive_q;

  // exact sum, divide toward zero, clamp
  always_comb begin
    acc     = AccW'(prod_i.prop) + AccW'(prod_i.intg) + AccW'(prod_i.deriv);
    quot    = acc[AccW-1:8] + QuotW'(acc[AccW-1] && (acc[7:0] != '0));
    lim_pos = QuotW'({1'b0, drive_limit_i});
    lim_neg = -lim_pos;
    if (prod_i.tgt_zero) begin
      drive_d = '0;
    end else if (quot > lim_pos) begin
      drive_d = lim_pos[CountW-1:0];
    end else if (quot < lim_neg) begin
      drive_d = lim_neg[CountW-1:0];
    end else begin
      drive_d = quot[CountW-1:0];
    end
  end

  // result valid
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drive_q <= drive_d;
    end
  end

  // result stays inside the symmetric limit
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> drive_q <= $signed({1'b0, drive_limit_i})
             && drive_q >= -$signed({1'b0, drive_limit_i}))
    else $error("drive word outside limit");

  // zero target gives a zero drive word
  a_zero_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && prod_i.tgt_zero |=> drive_q == '0)
    else $error("zero target did not force zero drive");

  // a product word taken always shows up as a result
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_q) else $error("output stage dropped a word");

endmodule

// ===== design/pid_speed_controller_clamped.sv =====
// top level of the clamped pid speed controller: config registers and pipeline
// depends on psc_pkg, psc_if, psc_error_stage, psc_gain_stage, psc_sum_clamp
//
//  channel  | dir | word
//  ---------+-----+-------------------------------------------
//  in_i     | in  | measured_count[15:0], target_speed[15:0]
//  out_o    | out | drive_value[15:0]
//  cfg      | in  | cfg_we_i, cfg_idx_i[1:0], cfg_data_i[14:0]
//
// three register stages: error terms, products, clamped result
// one word per cycle sustained while the output takes results; the result is offered
// once the word has passed the error terms, products and result registers
// the integral and previous error update when a word is accepted
// a stalled output backs up stage by stage; each stage refills as soon as it moves
// reset clears state and loads default gains and limit

module pid_speed_controller_clamped import psc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  psc_in_if.sink            in_i,
  psc_out_if.source         out_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [LimitW-1:0] cfg_data_i
);

  logic [GainW-1:0]  gain_p_q;
  logic [GainW-1:0]  gain_i_q;
  logic [GainW-1:0]  gain_d_q;
  logic [LimitW-1:0] limit_q;

  logic       terms_valid;
  logic       terms_ready;
  err_terms_t terms;
  logic       prod_valid;
  logic       prod_ready;
  products_t  prod;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= GainPReset;
      gain_i_q <= GainIReset;
      gain_d_q <= GainDReset;
      limit_q  <= LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_P:      gain_p_q <= cfg_data_i[GainW-1:0];
        CFG_GAIN_I:      gain_i_q <= cfg_data_i[GainW-1:0];
        CFG_GAIN_D:      gain_d_q <= cfg_data_i[GainW-1:0];
        CFG_DRIVE_LIMIT: limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  psc_error_stage u_error (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .measured_count_i (in_i.measured_count),
    .target_speed_i   (in_i.target_speed),
    .terms_valid_o    (terms_valid),
    .terms_ready_i    (terms_ready),
    .terms_o          (terms)
  );

  psc_gain_stage u_gain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gain_p_i      (gain_p_q),
    .gain_i_i      (gain_i_q),
    .gain_d_i      (gain_d_q),
    .terms_valid_i (terms_valid),
    .terms_ready_o (terms_ready),
    .terms_i       (terms),
    .prod_valid_o  (prod_valid),
    .prod_ready_i  (prod_ready),
    .prod_o        (prod)
  );

  psc_sum_clamp u_clamp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .drive_limit_i (limit_q),
    .prod_valid_i  (prod_valid),
    .prod_ready_o  (prod_ready),
    .prod_i        (prod),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .drive_value_o (out_o.drive_value)
  );

endmodule

// ===== verif/tb_pid_speed_controller_clamped.sv =====
// self-checking testbench for pid_speed_controller_clamped: random and directed words
// depends on psc_pkg, psc_if and the controller rtl; nothing else

module tb_pid_speed_controller_clamped;
  import psc_pkg::*;

  localparam longint SumMax     = 64'sd2147483647;
  localparam longint SumMin     = -64'sd2147483648;
  localparam int     CycleLimit = 1000000;
  localparam int     LongHold   = 120;

  typedef struct {
    logic signed [CountW-1:0] meas;
    logic signed [CountW-1:0] tgt;
  } speed_word_t;

  logic clk_i;
  logic rst_ni;
  logic              cfg_we_i;
  cfg_idx_e          cfg_idx_i;
  logic [LimitW-1:0] cfg_data_i;

  psc_in_if  in_ch ();
  psc_out_if out_ch ();

  pid_speed_controller_clamped dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // words waiting to be offered and drive values waiting to come out
  speed_word_t              speed_q[$];
  logic signed [CountW-1:0] drive_q[$];

  // controller state and registers as the testbench sees them
  logic [GainW-1:0]       kp_gain  = GainPReset;
  logic [GainW-1:0]       ki_gain  = GainIReset;
  logic [GainW-1:0]       kd_gain  = GainDReset;
  logic [LimitW-1:0]      lim_reg  = LimitReset;
  int                     err_acc  = 0;
  logic signed [ErrW-1:0] last_err = '0;

  int  fail_count  = 0;
  int  cycle_count = 0;
  bit  in_taken    = 1'b0;
  bit  tx_gaps_on  = 1'b1;
  bit  rx_gaps_on  = 1'b1;
  bit  rx_hold_req = 1'b0;
  int  tx_gap      = 0;
  int  rx_stall    = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one control tick: update integral and last error, return clamped drive
  function automatic logic signed [CountW-1:0] advance_pid(logic signed [CountW-1:0] meas,
                                                          logic signed [CountW-1:0] tgt);
    longint err;
    longint sum;
    longint acc;
    longint drv;
    longint lim;
    err = longint'(meas) - longint'(tgt);
    sum = longint'(err_acc) + err;
    if (sum > SumMax) sum = SumMax;
    else if (sum < SumMin) sum = SumMin;
    acc = longint'(kp_gain) * err + longint'(ki_gain) * sum
        + longint'(kd_gain) * (err - longint'(last_err));
    drv = acc / 256;
    lim = longint'(lim_reg);
    if (drv > lim) drv = lim;
    else if (drv < -lim) drv = -lim;
    if (tgt == 0) drv = 0;
    err_acc  = int'(sum);
    last_err = err[ErrW-1:0];
    return drv[CountW-1:0];
  endfunction

  task automatic flag_error(string what, int exp_v, int act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("error %0d at cycle %0d: %s expected %0d got %0d",
               fail_count, cycle_count, what, exp_v, act_v);
  endtask

  // input driver: holds a word until taken, then idles or offers the next
  always @(negedge clk_i) begin
    speed_word_t w;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // word still on offer
    end else if (tx_gap != 0) begin
      in_ch.valid <= 1'b0;
      tx_gap--;
    end else if (speed_q.size() != 0) begin
      w = speed_q.pop_front();
      in_ch.valid          <= 1'b1;
      in_ch.measured_count <= w.meas;
      in_ch.target_speed   <= w.tgt;
      tx_gap = tx_gaps_on ? pick_gap() : 0;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // result ready: random stalls, plus one long hold on request
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_stall = LongHold;
    end
    if (rx_stall == 0 && rx_gaps_on && rst_ni)
      rx_stall = pick_gap();
    if (rx_stall != 0) begin
      out_ch.ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: check results against the oldest prediction, predict accepted words
  always @(posedge clk_i) begin
    logic signed [CountW-1:0] exp_drive;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      in_taken <= rst_ni && in_ch.valid && in_ch.ready;
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          flag_error("unexpected drive word", 0, int'(out_ch.drive_value));
        end else begin
          exp_drive = drive_q.pop_front();
          if (out_ch.drive_value !== exp_drive)
            flag_error("drive_value", int'(exp_drive), int'(out_ch.drive_value));
        end
      end
      if (rst_ni && in_ch.valid && in_ch.ready)
        drive_q.push_back(advance_pid(in_ch.measured_count, in_ch.target_speed));
    end
  end

  task automatic push_word(int meas, int tgt);
    speed_word_t w;
    w.meas = meas[CountW-1:0];
    w.tgt  = tgt[CountW-1:0];
    speed_q.push_back(w);
  endtask

  // random word: tracking speeds, zero targets, extremes and full-range noise
  task automatic push_random_word();
    int r;
    int tgt;
    int picks[5];
    picks = '{-32768, 32767, 0, -1, 1};
    r = $urandom_range(0, 99);
    if (r < 10) begin
      push_word($urandom, 0);
    end else if (r < 20) begin
      push_word(picks[$urandom_range(0, 4)], picks[$urandom_range(0, 4)]);
    end else if (r < 60) begin
      tgt = int'($urandom_range(0, 6000)) - 3000;
      push_word(tgt + int'($urandom_range(0, 400)) - 200, tgt);
    end else begin
      push_word($urandom, $urandom);
    end
  endtask

  // register write while the pipeline is empty
  task automatic write_reg(cfg_idx_e idx, logic [LimitW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GAIN_P:      kp_gain = data[GainW-1:0];
      CFG_GAIN_I:      ki_gain = data[GainW-1:0];
      CFG_GAIN_D:      kd_gain = data[GainW-1:0];
      CFG_DRIVE_LIMIT: lim_reg = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [LimitW-1:0] kp, logic [LimitW-1:0] ki,
                          logic [LimitW-1:0] kd, logic [LimitW-1:0] lim);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    write_reg(CFG_DRIVE_LIMIT, lim);
    @(posedge clk_i);
  endtask

  // sender pause: wait until every word is taken and every result is back
  task automatic wait_drained();
    while (speed_q.size() != 0 || in_ch.valid || drive_q.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic run_random(int n);
    repeat (n) push_random_word();
    wait_drained();
  endtask

  // stimulus
  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_GAIN_P;
    cfg_data_i           = '0;
    in_ch.valid          = 1'b0;
    in_ch.measured_count = '0;
    in_ch.target_speed   = '0;
    out_ch.ready         = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed words at the reset gains: extremes, zero target, clamp both ways
    push_word(0, 0);
    push_word(32767, -32768);
    push_word(32767, -32768);
    push_word(-32768, 32767);
    push_word(100, 0);
    push_word(-32768, 0);
    push_word(500, 500);
    push_word(1500, 10);
    push_word(-1500, 10);
    push_word(21845, -21846);
    push_word(-21846, 21845);
    push_word(-1, 1);
    push_word(1, -1);
    push_word(32767, 32767);
    push_word(-32768, -32768);
    push_word(0, 32767);
    push_word(0, -32768);
    push_word(205, 200);
    wait_drained();
    run_random(40);

    // largest gains and limit; gain data with upper bits set
    set_regs(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    run_random(60);

    // zero gains
    set_regs(15'h0, 15'h0, 15'h0, 15'h7FFF);
    run_random(40);

    // zero limit
    set_regs(15'd1408, 15'd166, 15'd256, 15'h0);
    run_random(40);

    // back-pressure: sender never idles while the receiver holds off
    set_regs(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
             15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
    tx_gaps_on  = 1'b0;
    rx_gaps_on  = 1'b0;
    rx_hold_req = 1'b1;
    run_random(80);

    // large integral swings both ways, seen through the integral gain alone
    set_regs(15'h0, 15'h1, 15'h0, 15'h7FFF);
    for (int i = 0; i < 16; i++) begin
      if (i % 8 == 7) push_random_word();
      else push_word(32767, -32768);
    end
    for (int i = 0; i < 16; i++) begin
      if (i % 8 == 7) push_random_word();
      else push_word(-32768, 32767);
    end
    wait_drained();

    // random settings with idling on both sides
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (3) begin
      set_regs(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
               15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
      run_random(40);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
